// ----- design/bmh_pkg.sv -----
// ----------------------------------------------------------------------------
// bmh_pkg: shared definitions for the binary min-heap
// Sizes, status codes, the microcode control word, the datapath flag
// bundle and the read-only microprogram that sequences every operation.
// ----------------------------------------------------------------------------
package bmh_pkg;

  // Heap geometry and entry layout.
  localparam int HEAP_DEPTH = 1024;
  localparam int KEY_BITS   = 31;
  localparam int TAG_BITS   = 16;
  localparam int ENT_W      = KEY_BITS + TAG_BITS;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int OCC_BITS   = $clog2(HEAP_DEPTH + 1);
  localparam int CHI_W      = IDX_W + 2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

  // Command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Microprogram step addresses.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] S_DISP   = 4'd1;
  localparam logic [PC_W-1:0] S_PINIT  = 4'd2;
  localparam logic [PC_W-1:0] S_UPRD   = 4'd3;
  localparam logic [PC_W-1:0] S_UPCMP  = 4'd4;
  localparam logic [PC_W-1:0] S_PUT    = 4'd5;
  localparam logic [PC_W-1:0] S_FULLST = 4'd6;
  localparam logic [PC_W-1:0] S_POP0   = 4'd7;
  localparam logic [PC_W-1:0] S_POP1   = 4'd8;
  localparam logic [PC_W-1:0] S_POP2   = 4'd9;
  localparam logic [PC_W-1:0] S_DNL    = 4'd10;
  localparam logic [PC_W-1:0] S_DNR    = 4'd11;
  localparam logic [PC_W-1:0] S_DNSEL  = 4'd12;
  localparam logic [PC_W-1:0] S_DNCMP  = 4'd13;
  localparam logic [PC_W-1:0] S_EMPST  = 4'd14;
  localparam logic [PC_W-1:0] S_DONE   = 4'd15;

  // Jump condition codes.
  localparam logic [3:0] C_NONE         = 4'd0;
  localparam logic [3:0] C_ALWAYS       = 4'd1;
  localparam logic [3:0] C_NO_BEAT      = 4'd2;
  localparam logic [3:0] C_CMD_POP      = 4'd3;
  localparam logic [3:0] C_FULL         = 4'd4;
  localparam logic [3:0] C_POS_ZERO     = 4'd5;
  localparam logic [3:0] C_CUR_GE_RD    = 4'd6;
  localparam logic [3:0] C_EMPTY        = 4'd7;
  localparam logic [3:0] C_CNT_ZERO     = 4'd8;
  localparam logic [3:0] C_NO_LEFT      = 4'd9;
  localparam logic [3:0] C_NO_RIGHT     = 4'd10;
  localparam logic [3:0] C_RD_GE_CHILD  = 4'd11;
  localparam logic [3:0] C_CUR_LE_CHILD = 4'd12;
  localparam logic [3:0] C_OUT_BUSY     = 4'd13;

  // Read address sources.
  localparam logic [2:0] RD_NONE   = 3'd0;
  localparam logic [2:0] RD_PARENT = 3'd1;
  localparam logic [2:0] RD_ROOT   = 3'd2;
  localparam logic [2:0] RD_LAST   = 3'd3;
  localparam logic [2:0] RD_LEFT   = 3'd4;
  localparam logic [2:0] RD_RIGHT  = 3'd5;

  // Write data sources (always written at the hole position).
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_RD    = 2'd1;
  localparam logic [1:0] WR_CUR   = 2'd2;
  localparam logic [1:0] WR_CHILD = 2'd3;

  // Moving entry register sources.
  localparam logic [1:0] CUR_KEEP = 2'd0;
  localparam logic [1:0] CUR_IN   = 2'd1;
  localparam logic [1:0] CUR_RD   = 2'd2;

  // Result register sources.
  localparam logic [1:0] RES_KEEP = 2'd0;
  localparam logic [1:0] RES_ZERO = 2'd1;
  localparam logic [1:0] RES_RD   = 2'd2;

  // Chosen child register sources.
  localparam logic [1:0] CHD_KEEP  = 2'd0;
  localparam logic [1:0] CHD_LEFT  = 2'd1;
  localparam logic [1:0] CHD_RIGHT = 2'd2;

  // Hole position sources.
  localparam logic [2:0] POS_KEEP   = 3'd0;
  localparam logic [2:0] POS_CNT    = 3'd1;
  localparam logic [2:0] POS_PARENT = 3'd2;
  localparam logic [2:0] POS_ZERO   = 3'd3;
  localparam logic [2:0] POS_CHILD  = 3'd4;

  // Entry count operations.
  localparam logic [1:0] CNT_KEEP = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  // Status register operations.
  localparam logic [1:0] ST_KEEP  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // One microcode control word.
  typedef struct packed {
    logic            take;     // input channel open in this step
    logic [3:0]      cond;     // jump condition
    logic            gate;     // datapath actions only when the jump is not taken
    logic [PC_W-1:0] target;   // step when the condition holds
    logic [PC_W-1:0] fall;     // step otherwise
    logic [2:0]      rd_sel;
    logic [1:0]      wr_sel;
    logic [1:0]      cur_sel;
    logic [1:0]      res_sel;
    logic [1:0]      chd_sel;
    logic [2:0]      pos_sel;
    logic [1:0]      cnt_op;
    logic [1:0]      st_sel;
    logic            emit;     // load the output register
  } ucw_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic cmd_pop;
    logic full;
    logic pos_zero;
    logic cur_ge_rd;
    logic empty;
    logic cnt_zero;
    logic no_left;
    logic no_right;
    logic rd_ge_child;
    logic cur_le_child;
    logic out_busy;
  } bmh_flags_t;

  // The microprogram.
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '0;
    unique case (pc)
      S_IDLE: begin
        w.take = 1'b1; w.cond = C_NO_BEAT; w.target = S_IDLE; w.fall = S_DISP;
        w.cur_sel = CUR_IN; w.res_sel = RES_ZERO; w.st_sel = ST_CLEAR;
      end
      S_DISP: begin
        w.cond = C_CMD_POP; w.target = S_POP0; w.fall = S_PINIT;
      end
      S_PINIT: begin
        w.cond = C_FULL; w.gate = 1'b1; w.target = S_FULLST; w.fall = S_UPRD;
        w.pos_sel = POS_CNT; w.cnt_op = CNT_INC;
      end
      S_UPRD: begin
        w.cond = C_POS_ZERO; w.target = S_PUT; w.fall = S_UPCMP;
        w.rd_sel = RD_PARENT;
      end
      S_UPCMP: begin
        w.cond = C_CUR_GE_RD; w.gate = 1'b1; w.target = S_PUT; w.fall = S_UPRD;
        w.wr_sel = WR_RD; w.pos_sel = POS_PARENT;
      end
      S_PUT: begin
        w.cond = C_ALWAYS; w.target = S_DONE; w.fall = S_DONE;
        w.wr_sel = WR_CUR;
      end
      S_FULLST: begin
        w.cond = C_ALWAYS; w.target = S_DONE; w.fall = S_DONE;
        w.st_sel = ST_FULL;
      end
      S_POP0: begin
        w.cond = C_EMPTY; w.gate = 1'b1; w.target = S_EMPST; w.fall = S_POP1;
        w.rd_sel = RD_ROOT; w.cnt_op = CNT_DEC;
      end
      S_POP1: begin
        w.cond = C_CNT_ZERO; w.target = S_DONE; w.fall = S_POP2;
        w.res_sel = RES_RD; w.rd_sel = RD_LAST;
      end
      S_POP2: begin
        w.cond = C_NONE; w.target = S_DNL; w.fall = S_DNL;
        w.cur_sel = CUR_RD; w.pos_sel = POS_ZERO;
      end
      S_DNL: begin
        w.cond = C_NO_LEFT; w.target = S_PUT; w.fall = S_DNR;
        w.rd_sel = RD_LEFT;
      end
      S_DNR: begin
        w.cond = C_NO_RIGHT; w.target = S_DNCMP; w.fall = S_DNSEL;
        w.chd_sel = CHD_LEFT; w.rd_sel = RD_RIGHT;
      end
      S_DNSEL: begin
        w.cond = C_RD_GE_CHILD; w.gate = 1'b1; w.target = S_DNCMP; w.fall = S_DNCMP;
        w.chd_sel = CHD_RIGHT;
      end
      S_DNCMP: begin
        w.cond = C_CUR_LE_CHILD; w.gate = 1'b1; w.target = S_PUT; w.fall = S_DNL;
        w.wr_sel = WR_CHILD; w.pos_sel = POS_CHILD;
      end
      S_EMPST: begin
        w.cond = C_ALWAYS; w.target = S_DONE; w.fall = S_DONE;
        w.st_sel = ST_EMPTY;
      end
      S_DONE: begin
        w.cond = C_OUT_BUSY; w.gate = 1'b1; w.target = S_DONE; w.fall = S_IDLE;
        w.emit = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE; w.fall = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- design/bmh_ram.sv -----
// ----------------------------------------------------------------------------
// bmh_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bmh_useq.sv -----
// ----------------------------------------------------------------------------
// bmh_useq: microcode sequencer for the binary min-heap
// Holds the step counter, fetches the control word from the microprogram
// and resolves conditional jumps against the datapath flags.
// ----------------------------------------------------------------------------
module bmh_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  bmh_pkg::bmh_flags_t flags,
  output bmh_pkg::ucw_t       ctl,
  output logic                exec
);

  logic [bmh_pkg::PC_W-1:0] pc_r;
  logic [bmh_pkg::PC_W-1:0] pc_nxt;
  logic                     taken;

  // Fetch the control word for the current step.
  assign ctl = bmh_pkg::ucode(pc_r);

  // Evaluate the jump condition.
  always_comb begin
    unique case (ctl.cond)
      bmh_pkg::C_NONE:         taken = 1'b0;
      bmh_pkg::C_ALWAYS:       taken = 1'b1;
      bmh_pkg::C_NO_BEAT:      taken = !flags.in_valid;
      bmh_pkg::C_CMD_POP:      taken = flags.cmd_pop;
      bmh_pkg::C_FULL:         taken = flags.full;
      bmh_pkg::C_POS_ZERO:     taken = flags.pos_zero;
      bmh_pkg::C_CUR_GE_RD:    taken = flags.cur_ge_rd;
      bmh_pkg::C_EMPTY:        taken = flags.empty;
      bmh_pkg::C_CNT_ZERO:     taken = flags.cnt_zero;
      bmh_pkg::C_NO_LEFT:      taken = flags.no_left;
      bmh_pkg::C_NO_RIGHT:     taken = flags.no_right;
      bmh_pkg::C_RD_GE_CHILD:  taken = flags.rd_ge_child;
      bmh_pkg::C_CUR_LE_CHILD: taken = flags.cur_le_child;
      bmh_pkg::C_OUT_BUSY:     taken = flags.out_busy;
      default:                 taken = 1'b0;
    endcase
  end

  // Gated steps suppress their datapath actions when they jump.
  assign exec   = !(ctl.gate && taken);
  assign pc_nxt = taken ? ctl.target : ctl.fall;

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bmh_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- design/binary_min_heap.sv -----
// ----------------------------------------------------------------------------
// binary_min_heap: array-backed min-heap priority queue of key and tag pairs
// A microcoded sequencer drives a hole-based sift-up and sift-down over a
// single-port-read entry RAM and returns one result beat per command.
// ----------------------------------------------------------------------------
// The heap takes one command at a time and returns exactly one result beat
// for it. The entry RAM gives one registered read per cycle, so sift-up
// spends two steps per level (read parent, compare and move) and sift-down
// up to four (read left, read right, pick, compare and move); an entry moves
// at most 10 levels in a heap of 1024 entries. Push on full and pop on empty
// skip the sift. A finished result sits in an output register, and the
// block takes its next command while that result still waits. No clearing
// pass follows reset.
module binary_min_heap (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [bmh_pkg::KEY_BITS-1:0]  in_key_in,
  input  logic [bmh_pkg::TAG_BITS-1:0]  in_tag_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bmh_pkg::KEY_BITS-1:0]  out_key_out,
  output logic [bmh_pkg::TAG_BITS-1:0]  out_tag_out,
  output logic [1:0]                    out_status,
  output logic [bmh_pkg::OCC_BITS-1:0]  out_occupancy,
  output logic                          out_is_empty
);

  localparam int KB = bmh_pkg::KEY_BITS;
  localparam int TB = bmh_pkg::TAG_BITS;
  localparam int EW = bmh_pkg::ENT_W;
  localparam int IW = bmh_pkg::IDX_W;
  localparam int CW = bmh_pkg::OCC_BITS;
  localparam int HW = bmh_pkg::CHI_W;

  bmh_pkg::ucw_t       ctl;
  bmh_pkg::bmh_flags_t flags;
  logic                exec;

  // Datapath registers.
  logic          cmd_r;
  logic [KB-1:0] cur_key_r;
  logic [TB-1:0] cur_tag_r;
  logic [KB-1:0] res_key_r;
  logic [TB-1:0] res_tag_r;
  logic [KB-1:0] chd_key_r;
  logic [TB-1:0] chd_tag_r;
  logic [IW-1:0] chd_pos_r;
  logic [IW-1:0] pos_r;
  logic [IW-1:0] pos_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [1:0]    st_r;

  // Output register.
  logic          out_valid_r;
  logic [KB-1:0] out_key_r;
  logic [TB-1:0] out_tag_r;
  logic [1:0]    out_status_r;
  logic [CW-1:0] out_occ_r;

  // RAM interface.
  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [KB-1:0] rd_key;
  logic [TB-1:0] rd_tag;

  // Tree addressing around the hole.
  logic [IW-1:0] parent_idx;
  logic [HW-1:0] left_idx;
  logic [HW-1:0] right_idx;
  logic [HW-1:0] cnt_ext;
  logic          in_beat;
  logic          out_beat;

  assign rd_key     = ram_rdata[EW-1:TB];
  assign rd_tag     = ram_rdata[TB-1:0];
  assign parent_idx = (pos_r - IW'(1)) >> 1;
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = left_idx + HW'(1);
  assign cnt_ext    = HW'(cnt_r);

  assign in_stall = !ctl.take;
  assign in_beat  = in_valid && ctl.take;
  assign out_beat = out_valid_r && !out_stall;

  // Conditions for the sequencer.
  always_comb begin
    flags.in_valid     = in_valid;
    flags.cmd_pop      = (cmd_r == bmh_pkg::CMD_POP);
    flags.full         = (cnt_r == CW'(bmh_pkg::HEAP_DEPTH));
    flags.pos_zero     = (pos_r == '0);
    flags.cur_ge_rd    = (cur_key_r >= rd_key);
    flags.empty        = (cnt_r == '0);
    flags.cnt_zero     = (cnt_r == '0);
    flags.no_left      = (left_idx >= cnt_ext);
    flags.no_right     = (right_idx >= cnt_ext);
    flags.rd_ge_child  = (rd_key >= chd_key_r);
    flags.cur_le_child = (cur_key_r <= chd_key_r);
    flags.out_busy     = out_valid_r && out_stall;
  end

  bmh_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl),
    .exec  (exec)
  );

  // Read address selection.
  always_comb begin
    unique case (ctl.rd_sel)
      bmh_pkg::RD_PARENT: ram_raddr = parent_idx;
      bmh_pkg::RD_ROOT:   ram_raddr = '0;
      bmh_pkg::RD_LAST:   ram_raddr = cnt_r[IW-1:0];
      bmh_pkg::RD_LEFT:   ram_raddr = left_idx[IW-1:0];
      bmh_pkg::RD_RIGHT:  ram_raddr = right_idx[IW-1:0];
      default:            ram_raddr = '0;
    endcase
  end

  // Write data selection; writes always land at the hole.
  always_comb begin
    ram_we = exec && (ctl.wr_sel != bmh_pkg::WR_NONE);
    unique case (ctl.wr_sel)
      bmh_pkg::WR_RD:    ram_wdata = ram_rdata;
      bmh_pkg::WR_CUR:   ram_wdata = {cur_key_r, cur_tag_r};
      bmh_pkg::WR_CHILD: ram_wdata = {chd_key_r, chd_tag_r};
      default:           ram_wdata = ram_rdata;
    endcase
  end

  bmh_ram #(
    .WIDTH (EW),
    .DEPTH (bmh_pkg::HEAP_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hole position and entry count updates.
  always_comb begin
    pos_nxt = pos_r;
    if (exec) begin
      unique case (ctl.pos_sel)
        bmh_pkg::POS_CNT:    pos_nxt = cnt_r[IW-1:0];
        bmh_pkg::POS_PARENT: pos_nxt = parent_idx;
        bmh_pkg::POS_ZERO:   pos_nxt = '0;
        bmh_pkg::POS_CHILD:  pos_nxt = chd_pos_r;
        default:             pos_nxt = pos_r;
      endcase
    end
    cnt_nxt = cnt_r;
    if (exec) begin
      unique case (ctl.cnt_op)
        bmh_pkg::CNT_INC: cnt_nxt = cnt_r + CW'(1);
        bmh_pkg::CNT_DEC: cnt_nxt = cnt_r - CW'(1);
        default:          cnt_nxt = cnt_r;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (exec && ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_beat) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (in_beat) begin
      cmd_r <= in_cmd;
    end
    if (exec) begin
      unique case (ctl.cur_sel)
        bmh_pkg::CUR_IN: begin
          cur_key_r <= in_key_in;
          cur_tag_r <= in_tag_in;
        end
        bmh_pkg::CUR_RD: begin
          cur_key_r <= rd_key;
          cur_tag_r <= rd_tag;
        end
        default: begin
        end
      endcase
      unique case (ctl.res_sel)
        bmh_pkg::RES_ZERO: begin
          res_key_r <= '0;
          res_tag_r <= '0;
        end
        bmh_pkg::RES_RD: begin
          res_key_r <= rd_key;
          res_tag_r <= rd_tag;
        end
        default: begin
        end
      endcase
      unique case (ctl.chd_sel)
        bmh_pkg::CHD_LEFT: begin
          chd_key_r <= rd_key;
          chd_tag_r <= rd_tag;
          chd_pos_r <= left_idx[IW-1:0];
        end
        bmh_pkg::CHD_RIGHT: begin
          chd_key_r <= rd_key;
          chd_tag_r <= rd_tag;
          chd_pos_r <= right_idx[IW-1:0];
        end
        default: begin
        end
      endcase
      unique case (ctl.st_sel)
        bmh_pkg::ST_CLEAR: st_r <= bmh_pkg::STATUS_OK;
        bmh_pkg::ST_FULL:  st_r <= bmh_pkg::STATUS_PUSH_FULL;
        bmh_pkg::ST_EMPTY: st_r <= bmh_pkg::STATUS_POP_EMPTY;
        default: begin
        end
      endcase
      if (ctl.emit) begin
        out_key_r    <= res_key_r;
        out_tag_r    <= res_tag_r;
        out_status_r <= st_r;
        out_occ_r    <= cnt_r;
      end
    end
  end

  // Result beat.
  assign out_valid     = out_valid_r;
  assign out_key_out   = out_key_r;
  assign out_tag_out   = out_tag_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;
  assign out_is_empty  = (out_occ_r == '0);

endmodule

// ----- dv/binary_min_heap_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_test: self-checking bench for the binary min-heap
// A local copy of the heap predicts every result beat, including key, tag,
// status, occupancy and emptiness. Directed cases cover extremes and ties.
// A random mix moves occupancy up and down, and a fill pass hits the full
// heap before draining part of it in sorted order.
// ----------------------------------------------------------------------------
module binary_min_heap_test;

  localparam int KEY_BITS   = bmh_pkg::KEY_BITS;
  localparam int TAG_BITS   = bmh_pkg::TAG_BITS;
  localparam int OCC_BITS   = bmh_pkg::OCC_BITS;
  localparam int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_ITEMS = 96;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
  localparam logic [TAG_BITS-1:0] TAG_MAX = '1;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } heap_entry_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          status;
    logic [OCC_BITS-1:0] occupancy;
    logic                is_empty;
  } heap_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_cmd = bmh_pkg::CMD_PUSH;
  logic [KEY_BITS-1:0] in_key_in = '0;
  logic [TAG_BITS-1:0] in_tag_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KEY_BITS-1:0] out_key_out;
  logic [TAG_BITS-1:0] out_tag_out;
  logic [1:0]          out_status;
  logic [OCC_BITS-1:0] out_occupancy;
  logic                out_is_empty;

  // Local copy of the heap and the results still owed by the block.
  heap_entry_t  heap_slots [HEAP_DEPTH];
  int           heap_count = 0;
  heap_result_t op_results_q [$];

  // When set, neither side idles or stalls.
  bit steady = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int n_push_ok = 0;
  int n_pop_ok = 0;
  int n_pop_empty = 0;
  int n_push_full = 0;
  int peak_occupancy = 0;

  binary_min_heap i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_key_in     (in_key_in),
    .in_tag_in     (in_tag_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_key_out   (out_key_out),
    .out_tag_out   (out_tag_out),
    .out_status    (out_status),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void swap_heap_slots(input int a, input int b);
    heap_entry_t tmp;
    tmp = heap_slots[a];
    heap_slots[a] = heap_slots[b];
    heap_slots[b] = tmp;
  endfunction

  // Apply one command to the local heap and return the beat it must produce.
  function automatic heap_result_t apply_heap_op(input logic cmd,
                                                 input logic [KEY_BITS-1:0] key,
                                                 input logic [TAG_BITS-1:0] tag);
    heap_result_t r;
    int pos;
    int parent;
    int child;
    bit moving;
    r = '0;
    r.status = bmh_pkg::STATUS_OK;
    if (cmd == bmh_pkg::CMD_PUSH) begin
      if (heap_count >= HEAP_DEPTH) begin
        r.status = bmh_pkg::STATUS_PUSH_FULL;
        n_push_full++;
      end else begin
        // Append, then sift up past strictly larger parents only.
        pos = heap_count;
        heap_slots[pos] = '{key: key, tag: tag};
        heap_count++;
        moving = 1'b1;
        while (moving && pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_slots[pos].key >= heap_slots[parent].key) begin
            moving = 1'b0;
          end else begin
            swap_heap_slots(pos, parent);
            pos = parent;
          end
        end
        n_push_ok++;
      end
    end else begin
      if (heap_count == 0) begin
        r.status = bmh_pkg::STATUS_POP_EMPTY;
        n_pop_empty++;
      end else begin
        r.key = heap_slots[0].key;
        r.tag = heap_slots[0].tag;
        heap_count--;
        // Move the last entry to the root and sift it down; ties go left.
        if (heap_count > 0) begin
          heap_slots[0] = heap_slots[heap_count];
          pos = 0;
          moving = 1'b1;
          while (moving && 2 * pos + 1 < heap_count) begin
            child = 2 * pos + 1;
            if (child + 1 < heap_count && heap_slots[child + 1].key < heap_slots[child].key)
              child++;
            if (heap_slots[pos].key <= heap_slots[child].key) begin
              moving = 1'b0;
            end else begin
              swap_heap_slots(pos, child);
              pos = child;
            end
          end
        end
        n_pop_ok++;
      end
    end
    if (heap_count > peak_occupancy) peak_occupancy = heap_count;
    r.occupancy = heap_count[OCC_BITS-1:0];
    r.is_empty = (heap_count == 0);
    return r;
  endfunction

  // Result side: random stall, and every accepted beat checked in order.
  always @(posedge clk) begin
    heap_result_t want;
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 20);
    if (rst_n && out_valid && !out_stall) begin
      if (op_results_q.size() == 0) begin
        $display("%0t: unexpected result beat, key %0h tag %0h status %0d", $time,
                 out_key_out, out_tag_out, out_status);
        error_count++;
      end else begin
        want = op_results_q.pop_front();
        if (out_key_out !== want.key) begin
          $display("%0t: key_out expected %0h, got %0h", $time, want.key, out_key_out);
          error_count++;
        end
        if (out_tag_out !== want.tag) begin
          $display("%0t: tag_out expected %0h, got %0h", $time, want.tag, out_tag_out);
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d, got %0d", $time, want.occupancy,
                   out_occupancy);
          error_count++;
        end
        if (out_is_empty !== want.is_empty) begin
          $display("%0t: is_empty expected %0b, got %0b", $time, want.is_empty,
                   out_is_empty);
          error_count++;
        end
      end
    end
  end

  // Random key and tag over the full field width.
  function automatic logic [KEY_BITS-1:0] rand_key();
    return KEY_BITS'($urandom);
  endfunction

  function automatic logic [TAG_BITS-1:0] rand_tag();
    return TAG_BITS'($urandom);
  endfunction

  // Send one command beat, with an optional random gap of noise before it.
  task automatic send_heap_cmd(input logic cmd, input logic [KEY_BITS-1:0] key,
                               input logic [TAG_BITS-1:0] tag);
    heap_result_t owed;
    while (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      in_cmd <= 1'($urandom_range(1));
      in_key_in <= rand_key();
      in_tag_in <= rand_tag();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_key_in <= key;
    in_tag_in <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    owed = apply_heap_op(cmd, key, tag);
    op_results_q.insert(op_results_q.size(), owed);
  endtask

  // Hold off the sender until every owed result beat has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (op_results_q.size() != 0) @(posedge clk);
  endtask

  // Keys are a mix of full range, extremes and a tight range that forces ties.
  function automatic logic [KEY_BITS-1:0] pick_key();
    int mode;
    mode = $urandom_range(9);
    if (mode < 3) return KEY_BITS'($urandom_range(7));
    if (mode == 3) return ($urandom_range(1) != 0) ? KEY_MAX : '0;
    return rand_key();
  endfunction

  // Extremes, ties on both sift directions, and pops on an empty heap.
  task automatic test_directed_cases();
    int i;
    send_heap_cmd(bmh_pkg::CMD_POP, KEY_MAX, TAG_MAX);
    send_heap_cmd(bmh_pkg::CMD_PUSH, KEY_MAX, TAG_MAX);
    send_heap_cmd(bmh_pkg::CMD_PUSH, '0, '0);
    send_heap_cmd(bmh_pkg::CMD_PUSH, '0, 16'h0001);
    send_heap_cmd(bmh_pkg::CMD_PUSH, 31'h5, 16'hAAAA);
    send_heap_cmd(bmh_pkg::CMD_PUSH, 31'h5, 16'h5555);
    send_heap_cmd(bmh_pkg::CMD_PUSH, KEY_MAX, 16'h0001);
    for (i = 0; i < 7; i++) send_heap_cmd(bmh_pkg::CMD_POP, rand_key(), rand_tag());
    send_heap_cmd(bmh_pkg::CMD_POP, '0, '0);
    // Equal children under the root: the left one must win.
    send_heap_cmd(bmh_pkg::CMD_PUSH, 31'h1, 16'h0010);
    send_heap_cmd(bmh_pkg::CMD_PUSH, 31'h2, 16'h0020);
    send_heap_cmd(bmh_pkg::CMD_PUSH, 31'h2, 16'h0030);
    send_heap_cmd(bmh_pkg::CMD_PUSH, 31'h3, 16'h0040);
    for (i = 0; i < 5; i++) send_heap_cmd(bmh_pkg::CMD_POP, rand_key(), rand_tag());
    wait_for_results();
  endtask

  // Random mix that steers occupancy toward a target that keeps moving.
  task automatic test_random_mix();
    int i;
    int target;
    int pop_pct;
    target = 0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0:       target = $urandom_range(3);
          1:       target = $urandom_range(20, 60);
          default: target = $urandom_range(150, 300);
        endcase
      end
      steady = (i >= 100 && i < 200);
      if (i == 80 || i == 240) wait_for_results();
      pop_pct = (heap_count > target) ? 70 : 30;
      if ($urandom_range(99) < pop_pct)
        send_heap_cmd(bmh_pkg::CMD_POP, rand_key(), rand_tag());
      else
        send_heap_cmd(bmh_pkg::CMD_PUSH, pick_key(), rand_tag());
    end
    steady = 1'b0;
    wait_for_results();
  endtask

  // Fill the heap to capacity, push into the full heap, then drain part of it.
  task automatic test_fill_and_drain();
    int i;
    while (heap_count < HEAP_DEPTH)
      send_heap_cmd(bmh_pkg::CMD_PUSH, pick_key(), rand_tag());
    send_heap_cmd(bmh_pkg::CMD_PUSH, KEY_MAX, TAG_MAX);
    send_heap_cmd(bmh_pkg::CMD_PUSH, '0, '0);
    send_heap_cmd(bmh_pkg::CMD_POP, rand_key(), rand_tag());
    send_heap_cmd(bmh_pkg::CMD_PUSH, '0, TAG_MAX);
    send_heap_cmd(bmh_pkg::CMD_PUSH, rand_key(), rand_tag());
    for (i = 0; i < DRAIN_ITEMS; i++) send_heap_cmd(bmh_pkg::CMD_POP, rand_key(), rand_tag());
    wait_for_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_mix();
    test_fill_and_drain();
    // Let any stray beat surface before the verdict.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d pushes, %0d pops, %0d pops on empty, %0d pushes on full.",
             n_push_ok, n_pop_ok, n_pop_empty, n_push_full);
    $display("Peak occupancy %0d of %0d, %0d mismatches.", peak_occupancy, HEAP_DEPTH,
             error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
